// ----- sv/cosine_similarity_best_match_top_defines.svh -----
// assertion macros for the cosine similarity best match block
// used by cosine_similarity_best_match_top, needs clk and rst_n in scope
`ifndef COSINE_SIMILARITY_BEST_MATCH_TOP_DEFINES_SVH
`define COSINE_SIMILARITY_BEST_MATCH_TOP_DEFINES_SVH

// same-cycle implication
`define CSSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cssm assertion failed");

// next-cycle implication
`define CSSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cssm assertion failed");

`endif

// ----- sv/cssm_pkg.sv -----
// shared types and constants for the cosine similarity best match block
// no dependencies
package cssm_pkg;

    localparam int SQ_W   = 42;   // square sum accumulator
    localparam int RAD_W  = 58;   // square sum scaled by 2^16
    localparam int ROOT_W = 29;   // norm with 8 fraction bits
    localparam int Q_W    = 16;   // normalized element magnitude
    localparam int DIVD_W = 39;   // magnitude scaled by 2^23 plus half norm
    localparam int DSH_W  = ROOT_W + Q_W - 1;

    localparam logic [2:0] STAT_ADDED    = 3'd0;
    localparam logic [2:0] STAT_MISMATCH = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_QDONE    = 3'd3;
    localparam logic [2:0] STAT_QNONE    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_NRD,
        ST_NDIV_GO,
        ST_NDIV_WAIT,
        ST_DOT,
        ST_DOTEND
    } cssm_state_t;

endpackage

// ----- sv/cssm_sqrt.sv -----
// iterative integer square root, two radicand bits per cycle
// depends on cssm_pkg
module cssm_sqrt import cssm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0] n_reg, n_next;
    logic [RAD_W-1:0] r_reg, r_next;
    logic [RAD_W-1:0] b_reg, b_next;
    logic [4:0]       step_reg, step_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [RAD_W-1:0] trial;
    logic             ge;

    assign trial = r_reg + b_reg;
    assign ge    = n_reg >= trial;

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = radicand;
            r_next    = '0;
            b_next    = RAD_W'(1) << (RAD_W - 2);
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            n_next    = ge ? n_reg - trial : n_reg;
            r_next    = ge ? (r_reg >> 1) + b_reg : r_reg >> 1;
            b_next    = b_reg >> 2;
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(ROOT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

// ----- sv/cssm_div.sv -----
// restoring divider, one quotient bit per cycle, 16 bit quotient
// a set top bit means the true quotient is 32768 or more; depends on cssm_pkg
module cssm_div import cssm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [ROOT_W-1:0] divisor,
    output logic              done,
    output logic [Q_W-1:0]    quotient
);

    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DSH_W-1:0]  d_reg, d_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [4:0]        step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = DSH_W'(rem_reg) >= d_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            d_next    = {divisor, (Q_W-1)'(0)};
            q_next    = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? rem_reg - DIVD_W'(d_reg) : rem_reg;
            q_next    = {q_reg[Q_W-2:0], ge};
            d_next    = d_reg >> 1;
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(Q_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- sv/cosine_similarity_best_match_top.sv -----
// element transaction without last mark: result none; busy while its square is summed
// add: busy through the sqrt unit, then the shared divider per element
// query: as add, then a dot product per stored entry through one multiplier
// result strobe is registered, raised in the cycle after the work ends; receiver cannot stall
// async active low reset clears control, entry and element counts; stores keep contents
// depends on cssm_pkg, cssm_sqrt, cssm_div and the defines header
`include "cosine_similarity_best_match_top_defines.svh"

module cosine_similarity_best_match_top import cssm_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_DIM     = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic signed [15:0] element_value,
    input  logic               last_element,
    input  logic               cfg_wr_en,
    input  logic [9:0]         cfg_wr_data,
    output logic               result_valid,
    output logic [2:0]         status,
    output logic signed [15:0] similarity,
    output logic [6:0]         entry_count
);

    localparam int DA_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EC_W  = $clog2(MAX_DIM + 2);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SD    = MAX_ENTRIES * MAX_DIM;
    localparam int SA_W  = (SD > 1) ? $clog2(SD) : 1;
    localparam int ACC_W = 33 + DA_W;

    // staging buffer: incoming elements, later the normalized query in place
    logic signed [15:0] stage_mem [MAX_DIM];
    // table of normalized entries, one row of MAX_DIM words each
    logic signed [15:0] store_mem [SD];

    cssm_state_t state_reg, state_next;

    logic [9:0]          vlen_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [EC_W-1:0]     ec_reg, ec_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic signed [15:0]  x_reg, x_next;
    logic                op_reg, op_next;
    logic                last_reg, last_next;
    logic [SA_W-1:0]     base_reg, base_next;   // row of the next add
    logic [SA_W-1:0]     ebase_reg, ebase_next; // row being dotted
    logic [CNT_W-1:0]    e_reg, e_next;
    logic [DA_W-1:0]     i_reg, i_next;
    logic                idone_reg, idone_next;
    logic [ROOT_W-1:0]   r_reg, r_next;
    logic                neg_reg, neg_next;
    logic                v1_reg, v1_next, l1_reg, l1_next;
    logic                v2_reg, v2_next, l2_reg, l2_next;
    logic signed [31:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0]  best_reg, best_next;

    logic                res_v_reg, res_v_next;
    logic [2:0]          stat_reg, stat_next;
    logic signed [15:0]  sim_reg, sim_next;

    // memory ports
    logic                st_we;
    logic [DA_W-1:0]     st_waddr, st_raddr;
    logic signed [15:0]  st_wdata, st_rdata_reg;
    logic                sm_we;
    logic [SA_W-1:0]     sm_waddr, sm_raddr;
    logic signed [15:0]  sm_wdata, sm_rdata_reg;

    // shared multiplier: squares while staging, products while dotting
    logic signed [15:0]  mul_a, mul_b;
    logic signed [31:0]  mul_p;

    logic                sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                div_start, div_done;
    logic [DIVD_W-1:0]   div_dvd;
    logic [Q_W-1:0]      div_q;

    logic                match;
    logic                full;
    logic                at_last_idx;
    logic [15:0]         mag;
    logic [15:0]         norm_val;
    logic signed [ACC_W:0] rnd;
    logic signed [ACC_W:0] shq;
    logic signed [15:0]  dot_q15;

    assign mul_p = mul_a * mul_b;

    assign match = (vlen_reg != 10'd0) && (32'(vlen_reg) <= MAX_DIM)
                   && (32'(ec_reg) == 32'(vlen_reg));
    assign full  = 32'(cnt_reg) >= MAX_ENTRIES;
    assign at_last_idx = 32'(i_reg) == 32'(vlen_reg) - 1;

    // magnitude of the staged element, -32768 maps to 0x8000
    assign mag     = st_rdata_reg[15] ? 16'(16'd0 - st_rdata_reg) : st_rdata_reg;
    assign div_dvd = {mag, 23'd0} + DIVD_W'(r_reg >> 1);

    // saturate the quotient per sign, zero norm leaves zeros
    always_comb
    begin
        if (r_reg == '0)
            norm_val = 16'd0;
        else if (neg_reg)
            norm_val = div_q[15] ? 16'h8000 : 16'(16'd0 - div_q);
        else
            norm_val = (div_q >= 16'd32767) ? 16'h7fff : div_q;
    end

    // sum of q2.30 products (30 fraction bits) to q1.15 with round half up, then saturate
    always_comb
    begin
        rnd = $signed({acc_reg[ACC_W-1], acc_reg}) + $signed((ACC_W+1)'(16384));
        shq = rnd >>> 15;
        if (shq > $signed((ACC_W+1)'(32767)))
            dot_q15 = 16'sh7fff;
        else if (shq < -$signed((ACC_W+1)'(32768)))
            dot_q15 = -16'sh8000;
        else
            dot_q15 = shq[15:0];
    end

    cssm_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sq_reg, 16'd0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    cssm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (r_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ec_next    = ec_reg;
        sq_next    = sq_reg;
        x_next     = x_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        base_next  = base_reg;
        ebase_next = ebase_reg;
        e_next     = e_reg;
        i_next     = i_reg;
        idone_next = idone_reg;
        r_next     = r_reg;
        neg_next   = neg_reg;
        v1_next    = 1'b0;
        l1_next    = 1'b0;
        v2_next    = v1_reg;
        l2_next    = l1_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        best_next  = best_reg;
        res_v_next = 1'b0;
        stat_next  = stat_reg;
        sim_next   = sim_reg;
        st_we      = 1'b0;
        st_waddr   = ec_reg[DA_W-1:0];
        st_wdata   = element_value;
        st_raddr   = i_reg;
        sm_we      = 1'b0;
        sm_waddr   = base_reg + SA_W'(i_reg);
        sm_wdata   = norm_val;
        sm_raddr   = ebase_reg + SA_W'(i_reg);
        mul_a      = x_reg;
        mul_b      = x_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next    = element_value;
                    op_next   = op;
                    last_next = last_element;
                    // elements past the buffer are dropped, the count saturates
                    if (32'(ec_reg) < MAX_DIM)
                        st_we = 1'b1;
                    if (32'(ec_reg) <= MAX_DIM)
                        ec_next = ec_reg + EC_W'(1);
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (32'(ec_reg) <= MAX_DIM)
                    sq_next = sq_reg + SQ_W'($unsigned(mul_p));
                state_next = ST_IDLE;
                if (last_reg)
                begin
                    if (!op_reg && !match)
                    begin
                        res_v_next = 1'b1;
                        stat_next  = STAT_MISMATCH;
                        sim_next   = 16'sd0;
                    end
                    else if (!op_reg && full)
                    begin
                        res_v_next = 1'b1;
                        stat_next  = STAT_FULL;
                        sim_next   = 16'sd0;
                    end
                    else if (op_reg && (!match || cnt_reg == '0))
                    begin
                        res_v_next = 1'b1;
                        stat_next  = STAT_QNONE;
                        sim_next   = -16'sh8000;
                    end
                    else
                    begin
                        state_next = ST_SQRT_GO;
                    end
                    if (state_next == ST_IDLE)
                    begin
                        ec_next = '0;
                        sq_next = '0;
                    end
                end
            end
            ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    r_next     = sqrt_root;
                    i_next     = '0;
                    state_next = ST_NRD;
                end
            end
            ST_NRD:
            begin
                state_next = ST_NDIV_GO;
            end
            ST_NDIV_GO:
            begin
                neg_next   = st_rdata_reg[15];
                div_start  = 1'b1;
                state_next = ST_NDIV_WAIT;
            end
            ST_NDIV_WAIT:
            begin
                if (div_done)
                begin
                    // add writes the table row, query overwrites the staging slot
                    if (!op_reg)
                        sm_we = 1'b1;
                    else
                        st_we = 1'b1;
                    st_waddr = i_reg;
                    st_wdata = norm_val;
                    i_next   = i_reg + DA_W'(1);
                    if (!at_last_idx)
                    begin
                        state_next = ST_NRD;
                    end
                    else if (!op_reg)
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        base_next  = base_reg + SA_W'(MAX_DIM);
                        res_v_next = 1'b1;
                        stat_next  = STAT_ADDED;
                        sim_next   = 16'sd0;
                        ec_next    = '0;
                        sq_next    = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = '0;
                        ebase_next = '0;
                        i_next     = '0;
                        idone_next = 1'b0;
                        acc_next   = '0;
                        best_next  = -16'sh8000;
                        v2_next    = 1'b0;
                        l2_next    = 1'b0;
                        state_next = ST_DOT;
                    end
                end
            end
            ST_DOT:
            begin
                // issue reads, multiply read data, accumulate products
                mul_a     = st_rdata_reg;
                mul_b     = sm_rdata_reg;
                prod_next = mul_p;
                if (!idone_reg)
                begin
                    v1_next = 1'b1;
                    l1_next = at_last_idx;
                    i_next  = i_reg + DA_W'(1);
                    if (at_last_idx)
                        idone_next = 1'b1;
                end
                if (v2_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                if (v2_reg && l2_reg)
                    state_next = ST_DOTEND;
            end
            ST_DOTEND:
            begin
                v2_next = 1'b0;
                l2_next = 1'b0;
                if (dot_q15 > best_reg)
                    best_next = dot_q15;
                e_next = e_reg + CNT_W'(1);
                if (e_reg + CNT_W'(1) == cnt_reg)
                begin
                    res_v_next = 1'b1;
                    stat_next  = STAT_QDONE;
                    sim_next   = (dot_q15 > best_reg) ? dot_q15 : best_reg;
                    ec_next    = '0;
                    sq_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ebase_next = ebase_reg + SA_W'(MAX_DIM);
                    i_next     = '0;
                    idone_next = 1'b0;
                    acc_next   = '0;
                    state_next = ST_DOT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vlen_reg  <= 10'd128;
            cnt_reg   <= '0;
            ec_reg    <= '0;
            sq_reg    <= '0;
            base_reg  <= '0;
            res_v_reg <= 1'b0;
            v1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            l2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                vlen_reg <= cfg_wr_data;
            cnt_reg   <= cnt_next;
            ec_reg    <= ec_next;
            sq_reg    <= sq_next;
            base_reg  <= base_next;
            res_v_reg <= res_v_next;
            v1_reg    <= v1_next;
            l1_reg    <= l1_next;
            v2_reg    <= v2_next;
            l2_reg    <= l2_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        op_reg    <= op_next;
        last_reg  <= last_next;
        ebase_reg <= ebase_next;
        e_reg     <= e_next;
        i_reg     <= i_next;
        idone_reg <= idone_next;
        r_reg     <= r_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        stat_reg  <= stat_next;
        sim_reg   <= sim_next;
    end

    // staging buffer, registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
            stage_mem[st_waddr] <= st_wdata;
        st_rdata_reg <= stage_mem[st_raddr];
    end

    // entry table, registered read
    always_ff @(posedge clk)
    begin
        if (sm_we)
            store_mem[sm_waddr] <= sm_wdata;
        sm_rdata_reg <= store_mem[sm_raddr];
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = res_v_reg;
    assign status       = stat_reg;
    assign similarity   = sim_reg;
    assign entry_count  = 7'(cnt_reg);

    // strobe lasts one cycle since a result is raised only on the way back to idle
    `CSSM_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
    // an accepted transaction always makes the block busy next cycle
    `CSSM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a failed query carries the floor
    `CSSM_ASSERT_NOW(a_sim_code, result_valid && status == STAT_QNONE,
        similarity == -16'sh8000)
    // table never grows past its size
    `CSSM_ASSERT_NOW(a_count_bound, 1'b1, 32'(cnt_reg) <= MAX_ENTRIES)

endmodule
